// File: hw/rtl/dsi_pkg.sv
// dsi_pkg: shared types and constants of the diffuse shading block
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package dsi_pkg;

    // coefficient registers: 256 means 1.0
    localparam int COEF_BITS      = 9;
    localparam int COEF_PROD_BITS = 2 * COEF_BITS;
    // product of two coefficients carries 16 fraction bits
    localparam int COEF_SCALE_SHIFT = 16;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_AMBIENT_INTENSITY = 3'd0,
        REG_AMBIENT_COEF      = 3'd1,
        REG_POINT_INTENSITY   = 3'd2,
        REG_DIFFUSE_COEF      = 3'd3,
        REG_LIGHT_X           = 3'd4,
        REG_LIGHT_Y           = 3'd5,
        REG_LIGHT_Z           = 3'd6,
        REG_UNUSED            = 3'd7
    } cfg_reg_t;

    localparam logic [COEF_BITS-1:0] AMBIENT_INTENSITY_RST = 9'd256;
    localparam logic [COEF_BITS-1:0] AMBIENT_COEF_RST      = 9'd0;
    localparam logic [COEF_BITS-1:0] POINT_INTENSITY_RST   = 9'd256;
    localparam logic [COEF_BITS-1:0] DIFFUSE_COEF_RST      = 9'd256;

endpackage

// File: hw/rtl/dsi_sqrt_cell.sv
// dsi_sqrt_cell: one result bit of the pipelined integer square root
// no package dependencies; instantiated in a chain by the top level
`timescale 1ns / 1ps

module dsi_sqrt_cell #(
    parameter int X_W    = 34,
    parameter int R_W    = 17,
    parameter int J      = 0,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [X_W-1:0]    in_rem,
    input  logic [R_W-1:0]    in_root,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [X_W-1:0]    out_rem,
    output logic [R_W-1:0]    out_root,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [X_W-1:0]    rem_reg, rem_next;
    logic [R_W-1:0]    root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;
    logic [X_W:0]      trial;
    logic              fit;

    // (r + b)^2 - r^2 = r*2b + b^2 with b = 2^J
    always_comb begin
        trial     = ((X_W+1)'(in_root) << (J + 1)) | ((X_W+1)'(1) << (2 * J));
        fit       = {1'b0, in_rem} >= trial;
        rem_next  = fit ? (in_rem - trial[X_W-1:0]) : in_rem;
        root_next = fit ? (in_root | (R_W'(1) << J)) : in_root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/dsi_div_cell.sv
// dsi_div_cell: one quotient bit of the pipelined restoring divider
// no package dependencies; instantiated in a chain by the top level
`timescale 1ns / 1ps

module dsi_div_cell #(
    parameter int R_W    = 47,
    parameter int Q_W    = 16,
    parameter int D_W    = 33,
    parameter int SH     = 0,
    parameter int SIDE_W = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [R_W-1:0]    in_rem,
    input  logic [Q_W-1:0]    in_quot,
    input  logic [D_W-1:0]    in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [R_W-1:0]    out_rem,
    output logic [Q_W-1:0]    out_quot,
    output logic [D_W-1:0]    out_den,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [R_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]    quot_reg, quot_next;
    logic [D_W-1:0]    den_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [R_W:0]      trial;
    logic              fit;

    always_comb begin
        trial     = (R_W+1)'(in_den) << SH;
        fit       = {1'b0, in_rem} >= trial;
        rem_next  = fit ? (in_rem - trial[R_W-1:0]) : in_rem;
        quot_next = fit ? (in_quot | (Q_W'(1) << SH)) : in_quot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quot  = quot_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/diffuse_shade_intensity.sv
// diffuse_shade_intensity: lambert diffuse shading with an ambient term
// depends on dsi_pkg, dsi_sqrt_cell and dsi_div_cell
`timescale 1ns / 1ps

// Takes one vertex transaction per clock and returns one shaded intensity per
// vertex, in order. The light position is added to the vertex, its length is
// taken as a floor square root by a chain of one-bit cells (COORD_BITS+1 of
// them), the cosine N.L / (norm_len*|L|) comes from a chain of one-bit divide
// cells (OUT_FRAC_BITS+2 of them), saturated at +-4 and zero for a zero
// length. The intensity is ambient*coef, raised by point*diffuse*|cos| when
// the cosine is negative, clamped to 1.0 in signed Q1.OUT_FRAC_BITS.
// Throughput is one transaction per cycle unless m_tready stalls the output;
// results pass stages 1-3, the root chain, stages 4-5, the divide chain and stages
// 6-7. Every stage holds a valid bit and fills bubbles, so input is taken while a
// result waits at the output. Write configuration only while the pipeline is empty.
module diffuse_shade_intensity #(
    parameter int COORD_BITS    = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,
    // vert_x, vert_y, vert_z, norm_x, norm_y, norm_z, norm_len from bit 0 up
    input  logic [((7*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // intensity from bit 0
    output logic [((OUT_FRAC_BITS+2+7)/8)*8-1:0] m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // configuration write channel
    input  logic                                                  cfg_valid,
    output logic                                                  cfg_ready,
    input  logic [2:0]                                            cfg_addr,
    input  logic [(COORD_BITS > dsi_pkg::COEF_BITS ? COORD_BITS
                   : dsi_pkg::COEF_BITS)-1:0]                     cfg_data
);
    import dsi_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = OUT_FRAC_BITS;
    localparam int LW    = C + 1;          // light vector component
    localparam int SQW   = 2 * C + 2;      // sum of squares
    localparam int RTW   = C + 1;          // root of the sum of squares
    localparam int DOTW  = 2 * C + 2;      // signed dot product
    localparam int NUMW  = 2 * C + 1;      // dot magnitude
    localparam int DENW  = 2 * C + 2;      // norm_len * |L|
    localparam int REMW  = NUMW + F;       // scaled dividend
    localparam int QW    = F + 2;          // cosine magnitude below 4.0
    localparam int MW    = F + 3;          // cosine magnitude up to 4.0
    localparam int PRODW = COEF_PROD_BITS + MW;
    localparam int TOTW  = COEF_PROD_BITS + F + 4;
    localparam int OUTW  = F + 2;
    localparam int MDW   = ((OUTW + 7) / 8) * 8;
    localparam int SQ_SIDE = DOTW + C;
    localparam int DV_SIDE = 2;

    // ---------------- configuration registers ----------------
    logic [COEF_BITS-1:0] amb_int_reg, amb_coef_reg, pt_int_reg, dif_coef_reg;
    logic signed [C-1:0]  light_x_reg, light_y_reg, light_z_reg;
    logic [COEF_PROD_BITS-1:0] amb_prod_reg, dif_prod_reg;
    cfg_reg_t cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_reg_t'(cfg_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amb_int_reg  <= AMBIENT_INTENSITY_RST;
            amb_coef_reg <= AMBIENT_COEF_RST;
            pt_int_reg   <= POINT_INTENSITY_RST;
            dif_coef_reg <= DIFFUSE_COEF_RST;
            light_x_reg  <= '0;
            light_y_reg  <= '0;
            light_z_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_sel)
                REG_AMBIENT_INTENSITY: amb_int_reg  <= cfg_data[COEF_BITS-1:0];
                REG_AMBIENT_COEF:      amb_coef_reg <= cfg_data[COEF_BITS-1:0];
                REG_POINT_INTENSITY:   pt_int_reg   <= cfg_data[COEF_BITS-1:0];
                REG_DIFFUSE_COEF:      dif_coef_reg <= cfg_data[COEF_BITS-1:0];
                REG_LIGHT_X:           light_x_reg  <= cfg_data[C-1:0];
                REG_LIGHT_Y:           light_y_reg  <= cfg_data[C-1:0];
                REG_LIGHT_Z:           light_z_reg  <= cfg_data[C-1:0];
                default: begin
                end
            endcase
        end
    end

    // coefficient products are registered in the cycle after the registers change
    always_ff @(posedge aclk) begin
        amb_prod_reg <= amb_int_reg * amb_coef_reg;
        dif_prod_reg <= pt_int_reg * dif_coef_reg;
    end

    // ---------------- stage enables (bubble filling) ----------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic en1, en2, en3, en4, en5, en6, en7;
    logic [RTW:0] sq_v;
    logic [RTW:0] sq_en;
    logic [QW:0]  dv_v;
    logic [QW:0]  dv_en;

    assign en7 = !s7_v_reg || m_tready;
    assign en6 = !s6_v_reg || en7;
    assign dv_en[QW] = en6;
    assign en5 = !s5_v_reg || dv_en[0];
    assign en4 = !s4_v_reg || en5;
    assign sq_en[RTW] = en4;
    assign en3 = !s3_v_reg || sq_en[0];
    assign en2 = !s2_v_reg || en3;
    assign en1 = !s1_v_reg || en2;

    assign s_tready = en1;

    // ---------------- stage 1: light vector ----------------
    logic signed [C-1:0] vx, vy, vz, nx, ny, nz;
    logic [C-1:0]        nlen;
    logic signed [LW-1:0] lx_reg, ly_reg, lz_reg;
    logic signed [C-1:0]  nx1_reg, ny1_reg, nz1_reg;
    logic [C-1:0]         nlen1_reg;

    assign vx   = s_tdata[0*C +: C];
    assign vy   = s_tdata[1*C +: C];
    assign vz   = s_tdata[2*C +: C];
    assign nx   = s_tdata[3*C +: C];
    assign ny   = s_tdata[4*C +: C];
    assign nz   = s_tdata[5*C +: C];
    assign nlen = s_tdata[6*C +: C];

    always_ff @(posedge aclk) begin
        if (en1) begin
            lx_reg    <= LW'(vx) + LW'(light_x_reg);
            ly_reg    <= LW'(vy) + LW'(light_y_reg);
            lz_reg    <= LW'(vz) + LW'(light_z_reg);
            nx1_reg   <= nx;
            ny1_reg   <= ny;
            nz1_reg   <= nz;
            nlen1_reg <= nlen;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [2*LW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [DOTW-1:0] dpx_reg, dpy_reg, dpz_reg;
    logic [C-1:0]           nlen2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            sqx_reg   <= lx_reg * lx_reg;
            sqy_reg   <= ly_reg * ly_reg;
            sqz_reg   <= lz_reg * lz_reg;
            dpx_reg   <= DOTW'(nx1_reg) * DOTW'(lx_reg);
            dpy_reg   <= DOTW'(ny1_reg) * DOTW'(ly_reg);
            dpz_reg   <= DOTW'(nz1_reg) * DOTW'(lz_reg);
            nlen2_reg <= nlen1_reg;
        end
    end

    // ---------------- stage 3: sums ----------------
    logic [SQW-1:0]         sumsq_reg;
    logic signed [DOTW-1:0] dot3_reg;
    logic [C-1:0]           nlen3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            sumsq_reg <= SQW'(sqx_reg) + SQW'(sqy_reg) + SQW'(sqz_reg);
            dot3_reg  <= dpx_reg + dpy_reg + dpz_reg;
            nlen3_reg <= nlen2_reg;
        end
    end

    // ---------------- square root chain ----------------
    logic [SQW-1:0]     sq_rem  [RTW+1];
    logic [RTW-1:0]     sq_root [RTW+1];
    logic [SQ_SIDE-1:0] sq_side [RTW+1];

    assign sq_v[0]    = s3_v_reg;
    assign sq_rem[0]  = sumsq_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = {dot3_reg, nlen3_reg};

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        assign sq_en[k] = !sq_v[k+1] || sq_en[k+1];
        dsi_sqrt_cell #(
            .X_W    (SQW),
            .R_W    (RTW),
            .J      (RTW - 1 - k),
            .SIDE_W (SQ_SIDE)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (sq_en[k]),
            .in_valid  (sq_v[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_v[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    // ---------------- stage 4: denominator and magnitude ----------------
    logic signed [DOTW-1:0] dot_q;
    logic [C-1:0]           nlen_q;
    logic [DENW-1:0]        den4_reg;
    logic [NUMW-1:0]        num4_reg;
    logic                   neg4_reg;

    assign dot_q  = sq_side[RTW][SQ_SIDE-1 -: DOTW];
    assign nlen_q = sq_side[RTW][C-1:0];

    always_ff @(posedge aclk) begin
        if (en4) begin
            den4_reg <= DENW'(nlen_q) * DENW'(sq_root[RTW]);
            num4_reg <= dot_q[DOTW-1] ? NUMW'(-dot_q) : NUMW'(dot_q);
            neg4_reg <= dot_q[DOTW-1];
        end
    end

    // ---------------- stage 5: saturation check, dividend ----------------
    logic [REMW-1:0] rem5_reg;
    logic [DENW-1:0] den5_reg;
    logic            use5_reg, sat5_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            rem5_reg <= {num4_reg, {F{1'b0}}};
            den5_reg <= den4_reg;
            // only a negative cosine lights the surface; zero length gives zero
            use5_reg <= neg4_reg && (den4_reg != '0);
            sat5_reg <= (DENW+2)'(num4_reg) >= {den4_reg, 2'b00};
        end
    end

    // ---------------- divide chain ----------------
    logic [REMW-1:0]    dv_rem  [QW+1];
    logic [QW-1:0]      dv_quot [QW+1];
    logic [DENW-1:0]    dv_den  [QW+1];
    logic [DV_SIDE-1:0] dv_side [QW+1];

    assign dv_v[0]    = s5_v_reg;
    assign dv_rem[0]  = rem5_reg;
    assign dv_quot[0] = '0;
    assign dv_den[0]  = den5_reg;
    assign dv_side[0] = {use5_reg, sat5_reg};

    for (genvar k = 0; k < QW; k++) begin : g_div
        assign dv_en[k] = !dv_v[k+1] || dv_en[k+1];
        dsi_div_cell #(
            .R_W    (REMW),
            .Q_W    (QW),
            .D_W    (DENW),
            .SH     (QW - 1 - k),
            .SIDE_W (DV_SIDE)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (dv_en[k]),
            .in_valid  (dv_v[k]),
            .in_rem    (dv_rem[k]),
            .in_quot   (dv_quot[k]),
            .in_den    (dv_den[k]),
            .in_side   (dv_side[k]),
            .out_valid (dv_v[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_quot  (dv_quot[k+1]),
            .out_den   (dv_den[k+1]),
            .out_side  (dv_side[k+1])
        );
    end

    // ---------------- stage 6: diffuse term ----------------
    logic [MW-1:0]    cos_mag;
    logic [PRODW-1:0] dif6_reg;

    assign cos_mag = dv_side[QW][0] ? (MW'(4) << F) : MW'(dv_quot[QW]);

    always_ff @(posedge aclk) begin
        if (en6) begin
            dif6_reg <= dv_side[QW][1] ? (PRODW'(dif_prod_reg) * PRODW'(cos_mag)) : '0;
        end
    end

    // ---------------- stage 7: sum, scale, clamp ----------------
    localparam logic [TOTW-1:0] LIM = TOTW'(1) << F;
    logic [TOTW-1:0] total, scaled;
    logic [OUTW-1:0] res7_reg;

    always_comb begin
        total  = (TOTW'(amb_prod_reg) << F) + TOTW'(dif6_reg);
        scaled = total >> COEF_SCALE_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en7) begin
            res7_reg <= (scaled > LIM) ? OUTW'(LIM) : scaled[OUTW-1:0];
        end
    end

    // ---------------- valid bits of the plain stages ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end else begin
            if (en1) s1_v_reg <= s_tvalid;
            if (en2) s2_v_reg <= s1_v_reg;
            if (en3) s3_v_reg <= s2_v_reg;
            if (en4) s4_v_reg <= sq_v[RTW];
            if (en5) s5_v_reg <= s4_v_reg;
            if (en6) s6_v_reg <= dv_v[QW];
            if (en7) s7_v_reg <= s6_v_reg;
        end
    end

    assign m_tvalid = s7_v_reg;
    assign m_tdata  = MDW'(res7_reg);

`ifndef SYNTHESIS
    // input stalls only when the output is blocked and stages 1 and 6 are full
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && s1_v_reg && s6_v_reg))
        else $error("input stalled with room in the pipeline");

    // intensity never leaves [0, 1.0]
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res7_reg <= OUTW'(LIM)))
        else $error("intensity out of range");

    // nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // an enabled diffuse term needs a nonzero denominator
    a_sat_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (s5_v_reg && use5_reg) |-> (den5_reg != '0))
        else $error("diffuse term enabled with zero length");
`endif

endmodule
